// ===== hdl/ewc_pkg.sv =====
// ----------------------------------------------------------------------------
// ewc_pkg
// Shared types and constants of the EWC Fisher/anchor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ewc_pkg;

   localparam int VecDepthDefault   = 4096;
   localparam int CountWidthDefault = 16;

   localparam int IDX_W   = 12;
   localparam int VAL_W   = 32;
   localparam int PEN_W   = 63;
   localparam int FLOOR_W = 16;
   localparam int CSR_W   = 32;
   localparam int CSR_IDX_W = 1;
   // numerator of the running-mean update: (g*g >> 24) needs 39 bits
   localparam int NUM_W   = 39;

   localparam logic [1:0] KIND_ANCHOR = 2'd0;
   localparam logic [1:0] KIND_GRAD   = 2'd1;
   localparam logic [1:0] KIND_PARAM  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PULL  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR = 1'b1;

   typedef struct packed {
      logic [1:0]              kind;
      logic [IDX_W-1:0]        index;
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] new_param;
      logic [PEN_W-1:0]        penalty;
      logic                    penalty_valid;
      logic                    last_out;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/ewc_fisher_anchor_engine_core.sv =====
// ----------------------------------------------------------------------------
// ewc_fisher_anchor_engine_core
// EWC engine: anchor snapshot, diagonal Fisher running mean, parameter pull
// and penalty sum over anchor and Fisher RAMs.
//
//   channel   ports                              flow
//   request   start, busy, req_data              start taken when busy is low
//   response  rsp_valid, rsp_data                one-cycle strobe, no stall
//   csr       csr_we, csr_index, csr_wdata       write-only, taken at once
//
// one transaction at a time: an anchor write steps through S_LOAD and S_ANC,
// a gradient update waits on the bit-serial divider and a parameter update on
// the shared 32x32 multiplier (six passes).
// reset is synchronous and clears control and csr state only (floor to 1);
// RAM contents stay undefined until written, there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ewc_fisher_anchor_engine_core #(
   parameter int VEC_DEPTH   = ewc_pkg::VecDepthDefault,
   parameter int COUNT_WIDTH = ewc_pkg::CountWidthDefault
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire ewc_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   output ewc_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [ewc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ewc_pkg::CSR_W-1:0]        csr_wdata
);

   import ewc_pkg::*;

   localparam int AW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
   localparam int DW = COUNT_WIDTH + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_ANC, S_GSQ, S_GDIV,
      S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_PFIN
   } state_type;

   state_type               state_ff;
   logic [1:0]              kind_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic                    last_ff;
   logic                    inr_ff;
   logic [31:0]             pull_ff;
   logic [FLOOR_W-1:0]      floor_ff;
   logic [COUNT_WIDTH-1:0]  count_ff;
   logic                    snap_ff;
   logic [63:0]             sum_ff;
   logic [31:0]             f_ff;
   logic [31:0]             ad_ff;
   logic                    neg_ff;
   logic                    gneg_ff;
   logic [31:0]             hi_ff;
   logic [95:0]             acc_ff;
   logic [95:0]             acc2_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   // memories and shared units
   logic [AW-1:0] ram_addr;
   logic          anc_we;
   logic          fis_we;
   logic [31:0]   fis_wdata;
   logic [31:0]   anc_rd;
   logic [31:0]   fis_rd;
   logic [31:0]   mul_a;
   logic [31:0]   mul_b;
   logic [63:0]   prod;
   logic          div_start;
   logic [NUM_W-1:0] div_num;
   logic          div_done;
   logic [NUM_W-1:0] div_quo;

   ewc_ram #(.DEPTH(VEC_DEPTH), .WIDTH(32), .AW(AW)) u_anchor_ram (
      .clock(clock), .addr(ram_addr), .we(anc_we), .wdata(val_ff),
      .rdata_ff(anc_rd)
   );

   ewc_ram #(.DEPTH(VEC_DEPTH), .WIDTH(32), .AW(AW)) u_fisher_ram (
      .clock(clock), .addr(ram_addr), .we(fis_we), .wdata(fis_wdata),
      .rdata_ff(fis_rd)
   );

   ewc_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod_ff(prod));

   ewc_div #(.NW(NUM_W), .DW(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(DW'(count_ff) + DW'(1)), .done_ff(div_done), .quo_ff(div_quo)
   );

   // combinational helpers
   logic               req_inr_in;
   logic [31:0]        absv_in;
   logic signed [32:0] d_in;
   logic               dneg_in;
   logic [31:0]        ad_in;
   logic [40:0]        fseed_in;
   logic [31:0]        fseed_sat_in;
   logic [38:0]        g2_in;
   logic [39:0]        x_in;
   logic [40:0]        r_in;
   logic [31:0]        r_sat_in;
   logic [48:0]        m_in;
   logic [40:0]        mc_in;
   logic signed [42:0] np_wide_in;
   logic signed [31:0] np_in;
   logic               emit_in;
   logic signed [31:0] emit_np_in;
   logic [47:0]        emit_add_in;
   logic [64:0]        sum_add_in;
   logic [63:0]        sum_in;
   logic               count_full_in;

   always_comb begin
      req_inr_in = 32'(req_data.index) < 32'(VEC_DEPTH);
      absv_in    = val_ff[31] ? 32'(-val_ff) : val_ff;
      d_in       = {val_ff[31], val_ff} - {anc_rd[31], anc_rd};
      dneg_in    = d_in[32];
      ad_in      = dneg_in ? 32'(-d_in) : 32'(d_in);

      fseed_in     = 41'(prod[63:24]) + 41'(floor_ff);
      fseed_sat_in = (fseed_in > 41'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : fseed_in[31:0];

      g2_in   = prod[62:24];
      x_in    = {1'b0, g2_in} - 40'(f_ff);
      div_num = x_in[39] ? NUM_W'(40'(-x_in)) + NUM_W'(count_ff) : NUM_W'(x_in);

      // negative step rounds toward minus infinity via the ceiling above
      r_in = gneg_ff ? 41'(f_ff) - 41'(div_quo) : 41'(f_ff) + 41'(div_quo);
      if (r_in < 41'(floor_ff)) begin
         r_sat_in = 32'(floor_ff);
      end else if (r_in > 41'h0_FFFF_FFFF) begin
         r_sat_in = 32'hFFFF_FFFF;
      end else begin
         r_sat_in = r_in[31:0];
      end

      m_in  = 49'(acc_ff[95:48]) + 49'(neg_ff && (acc_ff[47:0] != '0));
      mc_in = (m_in > 49'(1) << 40) ? 41'(1) << 40 : 41'(m_in);
      np_wide_in = neg_ff ? 43'(val_ff) + $signed(43'(mc_in))
                          : 43'(val_ff) - $signed(43'(mc_in));
      if (np_wide_in > 43'sh0_7FFF_FFFF) begin
         np_in = 32'sh7FFF_FFFF;
      end else if (np_wide_in < -43'sh0_8000_0000) begin
         np_in = -32'sh8000_0000;
      end else begin
         np_in = 32'(np_wide_in);
      end

      emit_in     = 1'b0;
      emit_np_in  = val_ff;
      emit_add_in = '0;
      if (state_ff == S_LOAD && kind_ff == KIND_PARAM && !(snap_ff && inr_ff)) begin
         emit_in = 1'b1;
      end else if (state_ff == S_PFIN) begin
         emit_in     = 1'b1;
         emit_np_in  = np_in;
         emit_add_in = acc2_ff[95:48];
      end
      sum_add_in = 65'(sum_ff) + 65'(emit_add_in);
      sum_in     = sum_add_in[64] ? '1 : sum_add_in[63:0];

      count_full_in = (count_ff == '1);

      ram_addr  = (state_ff == S_IDLE) ? AW'(req_data.index) : AW'(idx_ff);
      anc_we    = (state_ff == S_ANC);
      fis_we    = (state_ff == S_ANC) || (state_ff == S_GDIV && div_done);
      fis_wdata = (state_ff == S_ANC) ? fseed_sat_in : r_sat_in;
      div_start = (state_ff == S_GSQ);

      case (state_ff)
         S_LOAD: begin
            mul_a = (kind_ff == KIND_PARAM) ? pull_ff : absv_in;
            mul_b = (kind_ff == KIND_PARAM) ? fis_rd : absv_in;
         end
         S_P1: begin
            mul_a = prod[31:0];
            mul_b = ad_ff;
         end
         S_P2: begin
            mul_a = hi_ff;
            mul_b = ad_ff;
         end
         S_P3: begin
            mul_a = ad_ff;
            mul_b = ad_ff;
         end
         S_P4: begin
            mul_a = f_ff;
            mul_b = prod[31:0];
         end
         S_P5: begin
            mul_a = f_ff;
            mul_b = hi_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pull_ff      <= '0;
         floor_ff     <= FLOOR_W'(1);
         count_ff     <= '0;
         snap_ff      <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;

         if (csr_we) begin
            case (csr_index)
               CSR_PULL:  pull_ff  <= csr_wdata;
               CSR_FLOOR: floor_ff <= csr_wdata[FLOOR_W-1:0];
               default: ;
            endcase
         end

         if (emit_in) begin
            rsp_valid_ff          <= 1'b1;
            rsp_ff.new_param      <= emit_np_in;
            rsp_ff.last_out       <= last_ff;
            rsp_ff.penalty_valid  <= last_ff;
            rsp_ff.penalty        <= (last_ff && snap_ff) ? sum_in[63:1] : '0;
            sum_ff                <= last_ff ? '0 : sum_in;
         end

         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  kind_ff  <= req_data.kind;
                  idx_ff   <= req_data.index;
                  val_ff   <= req_data.value;
                  last_ff  <= req_data.last;
                  inr_ff   <= req_inr_in;
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               f_ff   <= fis_rd;
               ad_ff  <= ad_in;
               neg_ff <= dneg_in;
               case (kind_ff)
                  KIND_ANCHOR: begin
                     if (inr_ff) begin
                        state_ff <= S_ANC;
                     end else begin
                        if (last_ff) begin
                           count_ff <= '0;
                           snap_ff  <= 1'b1;
                           sum_ff   <= '0;
                        end
                        state_ff <= S_IDLE;
                     end
                  end
                  KIND_GRAD: begin
                     if (snap_ff && inr_ff) begin
                        state_ff <= S_GSQ;
                     end else begin
                        if (snap_ff && last_ff && !count_full_in) begin
                           count_ff <= count_ff + COUNT_WIDTH'(1);
                        end
                        state_ff <= S_IDLE;
                     end
                  end
                  KIND_PARAM: begin
                     state_ff <= (snap_ff && inr_ff) ? S_P1 : S_IDLE;
                  end
                  default: state_ff <= S_IDLE;
               endcase
            end
            S_ANC: begin
               if (last_ff) begin
                  count_ff <= '0;
                  snap_ff  <= 1'b1;
                  sum_ff   <= '0;
               end
               state_ff <= S_IDLE;
            end
            S_GSQ: begin
               gneg_ff  <= x_in[39];
               state_ff <= S_GDIV;
            end
            S_GDIV: begin
               if (div_done) begin
                  if (last_ff && !count_full_in) begin
                     count_ff <= count_ff + COUNT_WIDTH'(1);
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_P1: begin
               hi_ff    <= prod[63:32];
               state_ff <= S_P2;
            end
            S_P2: begin
               acc_ff   <= 96'(prod);
               state_ff <= S_P3;
            end
            S_P3: begin
               acc_ff   <= acc_ff + {prod, 32'd0};
               state_ff <= S_P4;
            end
            S_P4: begin
               hi_ff    <= prod[63:32];
               state_ff <= S_P5;
            end
            S_P5: begin
               acc2_ff  <= 96'(prod);
               state_ff <= S_P6;
            end
            S_P6: begin
               acc2_ff  <= acc2_ff + {prod, 32'd0};
               state_ff <= S_PFIN;
            end
            S_PFIN: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a transaction in flight");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_penalty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.penalty_valid) |-> rsp_data.last_out)
      else $error("penalty reported on a non-last response");
`endif

endmodule

`default_nettype wire

// ===== hdl/ewc_ram.sv =====
// ----------------------------------------------------------------------------
// ewc_ram
// Single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ewc_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32,
   parameter int AW    = 12
) (
   input  wire logic             clock,
   input  wire logic [AW-1:0]    addr,
   input  wire logic             we,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

endmodule

`default_nettype wire

// ===== hdl/ewc_mul.sv =====
// ----------------------------------------------------------------------------
// ewc_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module ewc_mul (
   input  wire logic        clock,
   input  wire logic [31:0] op_a,
   input  wire logic [31:0] op_b,
   output logic      [63:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= 64'(op_a) * 64'(op_b);
   end

endmodule

`default_nettype wire

// ===== hdl/ewc_div.sv =====
// ----------------------------------------------------------------------------
// ewc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ewc_div #(
   parameter int NW = 39,
   parameter int DW = 17
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done_ff,
   output logic      [NW-1:0] quo_ff
);

   localparam int CW = (NW > 1) ? $clog2(NW) : 1;

   logic          run_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [DW:0]   shift_in;
   logic          ge_in;

   always_comb begin
      shift_in = {rem_ff, quo_ff[NW-1]};
      ge_in    = shift_in >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            den_ff <= den;
            quo_ff <= num;
         end else if (run_ff) begin
            rem_ff <= ge_in ? DW'(shift_in - {1'b0, den_ff}) : DW'(shift_in);
            quo_ff <= {quo_ff[NW-2:0], ge_in};
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== tb/ewc_fisher_anchor_engine_checker.sv =====
// ----------------------------------------------------------------------------
// ewc_fisher_anchor_engine_checker
// Watches the request, response and csr ports of the EWC engine, keeps its
// own anchor/Fisher state, predicts each parameter response and compares it
// field by field against what the engine puts out.
// ----------------------------------------------------------------------------
`default_nettype none

module ewc_fisher_anchor_engine_checker
   import ewc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire req_type              req_data,
   input  wire logic                 rsp_valid,
   input  wire rsp_type              rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   output int                        fail_count,
   output int                        pending,
   output int                        result_count,
   output int                        penalty_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0] pull_s;
   logic [31:0] floor_f;
   logic [31:0] anchor_mem [VecDepthDefault];
   logic [31:0] fisher_mem [VecDepthDefault];
   logic [15:0] obs_count;
   logic        snap_ok;
   logic [63:0] pen_sum;
   rsp_type     expected_rsp [$];

   function automatic logic [63:0] magnitude(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // updates the engine state for one accepted transaction
   task automatic apply_request(input req_type rq);
      longint      v, fv, g2, dv, xx, q, r, d, np, pull;
      logic [63:0] am, sq, ad;
      logic [127:0] prod, m, c;
      rsp_type     rs;
      v  = longint'(rq.value);
      am = magnitude(v);
      case (rq.kind)
         KIND_ANCHOR: begin
            sq = ((am * am) >> 24) + 64'(floor_f);
            anchor_mem[rq.index] = rq.value;
            fisher_mem[rq.index] = (sq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
            if (rq.last) begin
               obs_count = '0;
               snap_ok   = 1'b1;
               pen_sum   = '0;
            end
         end
         KIND_GRAD: begin
            if (snap_ok) begin
               fv = longint'({32'b0, fisher_mem[rq.index]});
               g2 = longint'((am * am) >> 24);
               dv = longint'(obs_count) + 1;
               xx = g2 - fv;
               // floor division of the running-mean step
               if (xx >= 0) q = xx / dv;
               else q = -((-xx + dv - 1) / dv);
               r = fv + q;
               if (r < longint'(floor_f)) r = longint'(floor_f);
               if (r > 64'sh0_FFFF_FFFF) r = 64'sh0_FFFF_FFFF;
               fisher_mem[rq.index] = r[31:0];
               if (rq.last && obs_count != 16'hFFFF) obs_count++;
            end
         end
         KIND_PARAM: begin
            np = v;
            if (snap_ok) begin
               d    = v - longint'($signed(anchor_mem[rq.index]));
               ad   = magnitude(d);
               prod = 128'(64'(pull_s) * 64'(fisher_mem[rq.index])) * 128'(ad);
               m    = prod >> 48;
               if (d < 0 && prod[47:0] != '0) m++;
               if (m > (128'd1 << 40)) m = 128'd1 << 40;
               pull = (d < 0) ? -longint'(m[63:0]) : longint'(m[63:0]);
               np   = v - pull;
               if (np > 64'sd2147483647) np = 64'sd2147483647;
               if (np < -64'sd2147483648) np = -64'sd2147483648;
               c = (128'(fisher_mem[rq.index]) * 128'(ad) * 128'(ad)) >> 48;
               pen_sum = (pen_sum > ~64'd0 - c[63:0]) ? ~64'd0 : pen_sum + c[63:0];
            end
            rs.new_param     = np[31:0];
            rs.penalty       = '0;
            rs.penalty_valid = 1'b0;
            rs.last_out      = rq.last;
            if (rq.last) begin
               rs.penalty       = snap_ok ? pen_sum[63:1] : '0;
               rs.penalty_valid = 1'b1;
               pen_sum          = '0;
            end
            expected_rsp = {expected_rsp, rs};
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type ex;
      if (reset) begin
         pull_s        = '0;
         floor_f       = 32'd1;
         obs_count     = '0;
         snap_ok       = 1'b0;
         pen_sum       = '0;
         expected_rsp.delete();
         fail_count    = 0;
         result_count  = 0;
         penalty_count = 0;
      end else begin
         if (rsp_valid) begin
            result_count++;
            if (expected_rsp.size() == 0) begin
               $error("response with no transaction outstanding");
               fail_count++;
            end else begin
               ex = expected_rsp.pop_front();
               if (ex.penalty_valid) penalty_count++;
               if (rsp_data.new_param !== ex.new_param) begin
                  $error("new_param exp %0d got %0d", ex.new_param, rsp_data.new_param);
                  fail_count++;
               end
               if (rsp_data.penalty !== ex.penalty) begin
                  $error("penalty exp %0d got %0d", ex.penalty, rsp_data.penalty);
                  fail_count++;
               end
               if (rsp_data.penalty_valid !== ex.penalty_valid) begin
                  $error("penalty_valid exp %0b got %0b",
                         ex.penalty_valid, rsp_data.penalty_valid);
                  fail_count++;
               end
               if (rsp_data.last_out !== ex.last_out) begin
                  $error("last_out exp %0b got %0b", ex.last_out, rsp_data.last_out);
                  fail_count++;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_PULL) pull_s = csr_wdata;
            else if (csr_index == CSR_FLOOR) floor_f = {16'b0, csr_wdata[FLOOR_W-1:0]};
         end
         if (start && !busy) apply_request(req_data);
      end
      pending = expected_rsp.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the EWC engine with directed and random anchor, gradient and
// parameter passes under several csr settings, with random start gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import ewc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_NONE = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;
   int                   fail_count, pending, result_count, penalty_count;

   bit                   written [VecDepthDefault];
   logic [31:0]          anchor_val [VecDepthDefault];
   int                   written_idx [$];
   bit                   snap_seen;
   int                   item_count;
   int                   cfg_count;

   ewc_fisher_anchor_engine_core u_top (
      .clock, .reset, .start, .busy, .req_data,
      .rsp_valid, .rsp_data, .csr_we, .csr_index, .csr_wdata
   );

   ewc_fisher_anchor_engine_checker u_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_we, .csr_index, .csr_wdata, .fail_count, .pending,
      .result_count, .penalty_count
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("tb_top: errors");
      $finish;
   end

   // wait for the engine to drain before touching the csrs
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      cfg_count++;
   endtask

   task automatic send(input logic [1:0] kind, input int idx, input logic [31:0] v,
                       input bit lst);
      int r, gap;
      req_data <= '{kind: kind, index: idx[IDX_W-1:0], value: v, last: lst};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      if (kind != KIND_NONE) item_count++;
      if (kind == KIND_ANCHOR) begin
         if (!written[idx]) written_idx = {written_idx, idx};
         written[idx]    = 1'b1;
         anchor_val[idx] = v;
         if (lst) snap_seen = 1'b1;
      end
      r = $urandom_range(0, 99);
      gap = (r < 45) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
         2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      endcase
   endfunction

   // once a snapshot is seen, gradient and parameter reads stay on anchored entries
   function automatic int pick_index();
      if (!snap_seen || written_idx.size() == 0) return $urandom_range(0, 4095);
      return written_idx[$urandom_range(0, written_idx.size() - 1)];
   endfunction

   function automatic logic [31:0] near_anchor(input int idx);
      if (!written[idx] || $urandom_range(0, 3) == 0) return rand_value();
      return anchor_val[idx] + 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
   endfunction

   initial begin
      int len, base, idx, npass;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      snap_seen = 1'b0;
      item_count = 0;
      cfg_count  = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no snapshot yet: pass-through, ignored gradient, ignored kind
      send(KIND_PARAM, 5, 32'h7FFF_FFFF, 1'b0);
      send(KIND_PARAM, 4095, 32'h8000_0000, 1'b1);
      send(KIND_GRAD, 9, 32'h7FFF_FFFF, 1'b1);
      send(KIND_NONE, 4095, 32'hFFFF_FFFF, 1'b1);
      settle();
      write_csr(CSR_PULL, 32'hFFFF_FFFF);
      write_csr(CSR_FLOOR, 32'h0000_FFFF);
      send(KIND_ANCHOR, 0, 32'h8000_0000, 1'b0);
      send(KIND_ANCHOR, 1, 32'h7FFF_FFFF, 1'b0);
      send(KIND_ANCHOR, 2, 32'h0000_0000, 1'b0);
      send(KIND_ANCHOR, 4095, 32'h0100_0000, 1'b0);
      send(KIND_ANCHOR, 3, 32'hFFFF_FFFF, 1'b1);
      send(KIND_GRAD, 0, 32'h7FFF_FFFF, 1'b0);
      send(KIND_GRAD, 2, 32'h8000_0000, 1'b0);
      send(KIND_GRAD, 4095, 32'h0000_0000, 1'b1);
      send(KIND_PARAM, 1, 32'h8000_0000, 1'b0);
      send(KIND_PARAM, 0, 32'h7FFF_FFFF, 1'b0);
      send(KIND_PARAM, 2, 32'h0000_0000, 1'b0);
      send(KIND_PARAM, 4095, 32'h0100_0000, 1'b1);
      send(KIND_GRAD, 3, 32'h0000_0001, 1'b1);
      send(KIND_PARAM, 3, 32'h7FFF_FFFF, 1'b1);
      send(KIND_NONE, 0, 32'h0, 1'b0);

      while (item_count < 1550) begin
         if ($urandom_range(0, 2) == 0) begin
            settle();
            case ($urandom_range(0, 3))
               0: write_csr(CSR_PULL, 32'h0);
               1: write_csr(CSR_PULL, 32'hFFFF_FFFF);
               2: write_csr(CSR_PULL, $urandom_range(0, 32'h0100_0000));
               default: write_csr(CSR_PULL, $urandom);
            endcase
            case ($urandom_range(0, 2))
               0: write_csr(CSR_FLOOR, 32'd1);
               1: write_csr(CSR_FLOOR, 32'hFFFF);
               default: write_csr(CSR_FLOOR, $urandom_range(1, 65535));
            endcase
         end
         // anchor pass over a short contiguous run
         len  = $urandom_range(1, 16);
         base = $urandom_range(0, 4095);
         for (int i = 0; i < len; i++)
            send(KIND_ANCHOR, (base + i) % 4096, rand_value(), i == len - 1);
         npass = $urandom_range(0, 3);
         for (int p = 0; p < npass; p++) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
               send(KIND_GRAD, pick_index(), rand_value(), i == len - 1);
         end
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            idx = pick_index();
            send(KIND_PARAM, idx, near_anchor(idx), i == len - 1);
         end
         // noise: stray kinds and broken passes
         if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++)
               send(2'($urandom_range(1, 3)), pick_index(), rand_value(),
                    1'($urandom_range(0, 1)));
         end
      end

      settle();
      $display("tb_top: %0d transactions, %0d csr writes, %0d responses (%0d penalties)",
               item_count, cfg_count, result_count, penalty_count);
      if (fail_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
